>>> design/utterance_endpoint_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the utterance endpoint detector
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef UTTERANCE_ENDPOINT_DETECTOR_UNIT_ASSERT_SVH
`define UTTERANCE_ENDPOINT_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/uted_pkg.sv
// ----------------------------------------------------------------------------
// uted_pkg
// Shared types, register map and reset values of the endpoint detector.
// ----------------------------------------------------------------------------
package uted_pkg;

   localparam int TIMER_WIDTH_DEF = 16;
   localparam int LEVEL_WIDTH_DEF = 15;

   // configuration field widths
   localparam int THRESH_W = 15;
   localparam int TICK_W   = 10;
   localparam int MS_W     = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_LEVEL_THRESHOLD   = 3'd0;
   localparam logic [2:0] REG_TICK_MS           = 3'd1;
   localparam logic [2:0] REG_BURST_MS          = 3'd2;
   localparam logic [2:0] REG_SILENCE_END_MS    = 3'd3;
   localparam logic [2:0] REG_MAX_LENGTH_MS     = 3'd4;
   localparam logic [2:0] REG_MIN_LENGTH_MS     = 3'd5;
   localparam logic [2:0] REG_PARTIAL_PERIOD_MS = 3'd6;

   localparam logic [THRESH_W-1:0] RST_LEVEL_THRESHOLD   = 15'd25;
   localparam logic [TICK_W-1:0]   RST_TICK_MS           = 10'd100;
   localparam logic [MS_W-1:0]     RST_BURST_MS          = 16'd150;
   localparam logic [MS_W-1:0]     RST_SILENCE_END_MS    = 16'd800;
   localparam logic [MS_W-1:0]     RST_MAX_LENGTH_MS     = 16'd15000;
   localparam logic [MS_W-1:0]     RST_MIN_LENGTH_MS     = 16'd300;
   localparam logic [MS_W-1:0]     RST_PARTIAL_PERIOD_MS = 16'd500;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_PRIMED = 2'd1,
      PH_SPEECH = 2'd2
   } phase_type;

   typedef struct packed {
      logic [THRESH_W-1:0] level_threshold;
      logic [TICK_W-1:0]   tick_ms;
      logic [MS_W-1:0]     burst_ms;
      logic [MS_W-1:0]     silence_end_ms;
      logic [MS_W-1:0]     max_length_ms;
      logic [MS_W-1:0]     min_length_ms;
      logic [MS_W-1:0]     partial_period_ms;
   } cfg_type;

   typedef struct packed {
      logic flush_all;
      logic trim_preroll;
      logic utterance_start;
      logic partial_request;
      logic final_decode;
      logic final_discard;
   } flags_type;

endpackage

>>> design/utterance_endpoint_detector_unit.sv
// ----------------------------------------------------------------------------
// utterance_endpoint_detector_unit
// Energy-threshold voice activity detector with hangover: one poll tick in,
// one endpoint result out.
// ----------------------------------------------------------------------------
//
//   channel  | ports   | moves
//   ---------+---------+-----------------------------------------------------
//   request  | req_*   | level, mic_active for one poll tick
//   result   | rsp_*   | phase, six event flags, speech_length_ms
//   control  | csr_*   | seven configuration registers, 4-byte spaced
//
// Flow: a request is accepted into the input register, then moves into the
// result register when that register is empty or being drained, and its
// result is offered from the result register.
// One request per cycle is sustained while rsp_tready stays high; the phase
// and timer registers close their feedback loop through the step logic.
// Stalls: while rsp_tready is low, one further request may wait in the input
// register; req_tready drops only when both registers are full and
// rsp_tready is low.
// Reset: synchronous, active high; clears phase, timers, valid flags and
// loads the configuration defaults.
//
module utterance_endpoint_detector_unit #(
   parameter int TIMER_WIDTH = uted_pkg::TIMER_WIDTH_DEF,
   parameter int LEVEL_WIDTH = uted_pkg::LEVEL_WIDTH_DEF,
   parameter int REQ_W = ((LEVEL_WIDTH + 1 + 7) / 8) * 8,
   parameter int RSP_W = ((TIMER_WIDTH + 8 + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [LEVEL_WIDTH-1:0] level, [LEVEL_WIDTH] mic_active, zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_W-1:0]                req_tdata,
   // result: [1:0] phase, [2] flush_all, [3] trim_preroll, [4] utterance_start,
   //   [5] partial_request, [6] final_decode, [7] final_discard,
   //   [TIMER_WIDTH+7:8] speech_length_ms, zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_W-1:0]                rsp_tdata,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [uted_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [uted_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [uted_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

`include "utterance_endpoint_detector_unit_assert.svh"

   localparam int DW = uted_pkg::CSR_DATA_W;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   uted_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_wr;
   logic [2:0]        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            uted_pkg::REG_LEVEL_THRESHOLD:
               cfg_in.level_threshold = csr_pwdata[uted_pkg::THRESH_W-1:0];
            uted_pkg::REG_TICK_MS:
               cfg_in.tick_ms = csr_pwdata[uted_pkg::TICK_W-1:0];
            uted_pkg::REG_BURST_MS:
               cfg_in.burst_ms = csr_pwdata[uted_pkg::MS_W-1:0];
            uted_pkg::REG_SILENCE_END_MS:
               cfg_in.silence_end_ms = csr_pwdata[uted_pkg::MS_W-1:0];
            uted_pkg::REG_MAX_LENGTH_MS:
               cfg_in.max_length_ms = csr_pwdata[uted_pkg::MS_W-1:0];
            uted_pkg::REG_MIN_LENGTH_MS:
               cfg_in.min_length_ms = csr_pwdata[uted_pkg::MS_W-1:0];
            uted_pkg::REG_PARTIAL_PERIOD_MS:
               cfg_in.partial_period_ms = csr_pwdata[uted_pkg::MS_W-1:0];
            default: begin
               // drop writes beyond the register map
            end
         endcase
      end
   end

   // read back: zero-extend the addressed register
   always_comb begin
      case (csr_idx)
         uted_pkg::REG_LEVEL_THRESHOLD:   csr_prdata = DW'(cfg_ff.level_threshold);
         uted_pkg::REG_TICK_MS:           csr_prdata = DW'(cfg_ff.tick_ms);
         uted_pkg::REG_BURST_MS:          csr_prdata = DW'(cfg_ff.burst_ms);
         uted_pkg::REG_SILENCE_END_MS:    csr_prdata = DW'(cfg_ff.silence_end_ms);
         uted_pkg::REG_MAX_LENGTH_MS:     csr_prdata = DW'(cfg_ff.max_length_ms);
         uted_pkg::REG_MIN_LENGTH_MS:     csr_prdata = DW'(cfg_ff.min_length_ms);
         uted_pkg::REG_PARTIAL_PERIOD_MS: csr_prdata = DW'(cfg_ff.partial_period_ms);
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold   <= uted_pkg::RST_LEVEL_THRESHOLD;
         cfg_ff.tick_ms           <= uted_pkg::RST_TICK_MS;
         cfg_ff.burst_ms          <= uted_pkg::RST_BURST_MS;
         cfg_ff.silence_end_ms    <= uted_pkg::RST_SILENCE_END_MS;
         cfg_ff.max_length_ms     <= uted_pkg::RST_MAX_LENGTH_MS;
         cfg_ff.min_length_ms     <= uted_pkg::RST_MIN_LENGTH_MS;
         cfg_ff.partial_period_ms <= uted_pkg::RST_PARTIAL_PERIOD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // input register and pipeline control
   // ---------------------------------------------------------------------
   logic                   in_valid_ff;
   logic [LEVEL_WIDTH-1:0] in_level_ff;
   logic                   in_mic_ff;
   logic                   req_fire;
   logic                   step_fire;
   logic                   rsp_free;
   logic                   rsp_valid;

   // the result register can take a new tick if empty or being drained
   assign rsp_free   = !rsp_valid || rsp_tready;
   assign step_fire  = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload: hold while stalled, load on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_level_ff <= req_tdata[LEVEL_WIDTH-1:0];
         in_mic_ff   <= req_tdata[LEVEL_WIDTH];
      end
   end

   // ---------------------------------------------------------------------
   // detector state and step logic
   // ---------------------------------------------------------------------
   uted_pkg::phase_type    phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] primed_ff, primed_in;
   logic [TIMER_WIDTH-1:0] speech_ff, speech_in;
   logic [TIMER_WIDTH-1:0] silence_ff, silence_in;
   logic [TIMER_WIDTH-1:0] partial_ff, partial_in;
   uted_pkg::flags_type    flags_in;
   logic [TIMER_WIDTH-1:0] length_in;

   uted_step #(
      .TIMER_WIDTH (TIMER_WIDTH),
      .LEVEL_WIDTH (LEVEL_WIDTH)
   ) u_step (
      .cfg              (cfg_ff),
      .level            (in_level_ff),
      .mic_active       (in_mic_ff),
      .cur_phase        (phase_ff),
      .cur_primed       (primed_ff),
      .cur_speech       (speech_ff),
      .cur_silence      (silence_ff),
      .cur_partial      (partial_ff),
      .nxt_phase        (phase_in),
      .nxt_primed       (primed_in),
      .nxt_speech       (speech_in),
      .nxt_silence      (silence_in),
      .nxt_partial      (partial_in),
      .flags            (flags_in),
      .speech_length_ms (length_in)
   );

   // advance the detector state only when the tick moves into the result
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= uted_pkg::PH_IDLE;
         primed_ff  <= '0;
         speech_ff  <= '0;
         silence_ff <= '0;
         partial_ff <= '0;
      end else if (step_fire) begin
         phase_ff   <= phase_in;
         primed_ff  <= primed_in;
         speech_ff  <= speech_in;
         silence_ff <= silence_in;
         partial_ff <= partial_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic                   rsp_valid_ff;
   uted_pkg::phase_type    rsp_phase_ff;
   uted_pkg::flags_type    rsp_flags_ff;
   logic [TIMER_WIDTH-1:0] rsp_length_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_phase_ff  <= phase_in;
         rsp_flags_ff  <= flags_in;
         rsp_length_ff <= length_in;
      end
   end

   // pack: phase lowest, then the flags, then the length; the cast zero-fills
   assign rsp_tdata = RSP_W'({rsp_length_ff,
                              rsp_flags_ff.final_discard,
                              rsp_flags_ff.final_decode,
                              rsp_flags_ff.partial_request,
                              rsp_flags_ff.utterance_start,
                              rsp_flags_ff.trim_preroll,
                              rsp_flags_ff.flush_all,
                              rsp_phase_ff});

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `UTED_ASSERT_NOW(a_end_goes_idle, clock, reset,
      rsp_valid_ff && (rsp_flags_ff.final_decode || rsp_flags_ff.final_discard),
      rsp_phase_ff == uted_pkg::PH_IDLE,
      "utterance end did not return the phase to idle")
   `UTED_ASSERT_NOW(a_flush_alone, clock, reset,
      rsp_valid_ff && rsp_flags_ff.flush_all,
      rsp_phase_ff == uted_pkg::PH_IDLE && rsp_length_ff == '0 &&
      !rsp_flags_ff.utterance_start && !rsp_flags_ff.partial_request &&
      !rsp_flags_ff.final_decode && !rsp_flags_ff.final_discard,
      "flush result carries other events")
   `UTED_ASSERT_NOW(a_start_in_speech, clock, reset,
      rsp_valid_ff && rsp_flags_ff.utterance_start,
      rsp_phase_ff == uted_pkg::PH_SPEECH && !rsp_flags_ff.partial_request,
      "utterance start without speech phase or with a partial request")
   `UTED_ASSERT_NEXT(a_step_updates_state, clock, reset,
      step_fire,
      rsp_valid_ff && phase_ff == rsp_phase_ff,
      "state register and result phase disagree after a step")

endmodule

>>> design/uted_step.sv
// ----------------------------------------------------------------------------
// uted_step
// Next phase, timers and result flags for one poll tick.
// ----------------------------------------------------------------------------
module uted_step #(
   parameter int TIMER_WIDTH = uted_pkg::TIMER_WIDTH_DEF,
   parameter int LEVEL_WIDTH = uted_pkg::LEVEL_WIDTH_DEF
) (
   input  uted_pkg::cfg_type        cfg,
   input  logic [LEVEL_WIDTH-1:0]   level,
   input  logic                     mic_active,
   input  uted_pkg::phase_type      cur_phase,
   input  logic [TIMER_WIDTH-1:0]   cur_primed,
   input  logic [TIMER_WIDTH-1:0]   cur_speech,
   input  logic [TIMER_WIDTH-1:0]   cur_silence,
   input  logic [TIMER_WIDTH-1:0]   cur_partial,
   output uted_pkg::phase_type      nxt_phase,
   output logic [TIMER_WIDTH-1:0]   nxt_primed,
   output logic [TIMER_WIDTH-1:0]   nxt_speech,
   output logic [TIMER_WIDTH-1:0]   nxt_silence,
   output logic [TIMER_WIDTH-1:0]   nxt_partial,
   output uted_pkg::flags_type      flags,
   output logic [TIMER_WIDTH-1:0]   speech_length_ms
);

   localparam int SUM_W = ((TIMER_WIDTH > uted_pkg::TICK_W) ?
                           TIMER_WIDTH : uted_pkg::TICK_W) + 1;
   localparam int CMP_W = (TIMER_WIDTH > uted_pkg::MS_W) ? TIMER_WIDTH : uted_pkg::MS_W;
   localparam int LVL_W = (LEVEL_WIDTH > uted_pkg::THRESH_W) ?
                          LEVEL_WIDTH : uted_pkg::THRESH_W;
   localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

   function automatic logic [TIMER_WIDTH-1:0] sat_add(input logic [TIMER_WIDTH-1:0] t,
                                                      input logic [uted_pkg::TICK_W-1:0] d);
      logic [SUM_W-1:0] s;
      s = SUM_W'(t) + SUM_W'(d);
      if (s > SUM_W'(TMAX)) begin
         return TMAX;
      end
      return s[TIMER_WIDTH-1:0];
   endfunction

   // true when timer t has reached limit m
   function automatic logic reached(input logic [TIMER_WIDTH-1:0] t,
                                    input logic [uted_pkg::MS_W-1:0] m);
      return CMP_W'(t) >= CMP_W'(m);
   endfunction

   logic [LVL_W-1:0]        thr_cmp;
   logic                    sound;
   logic [TIMER_WIDTH-1:0]  primed_add;
   logic [TIMER_WIDTH-1:0]  speech_add;
   logic [TIMER_WIDTH-1:0]  silence_add;
   logic [TIMER_WIDTH-1:0]  partial_add;

   // threshold is masked down to the level width before the compare
   assign thr_cmp    = LVL_W'(cfg.level_threshold) & LVL_W'({LEVEL_WIDTH{1'b1}});
   assign sound      = LVL_W'(level) > thr_cmp;
   assign primed_add = sat_add(cur_primed, cfg.tick_ms);
   assign speech_add = sat_add(cur_speech, cfg.tick_ms);
   assign silence_add = sound ? '0 : sat_add(cur_silence, cfg.tick_ms);
   assign partial_add = sat_add(cur_partial, cfg.tick_ms);

   always_comb begin
      nxt_phase        = cur_phase;
      nxt_primed       = cur_primed;
      nxt_speech       = cur_speech;
      nxt_silence      = cur_silence;
      nxt_partial      = cur_partial;
      flags            = '0;
      speech_length_ms = '0;
      if (!mic_active) begin
         nxt_phase       = uted_pkg::PH_IDLE;
         flags.flush_all = 1'b1;
      end else begin
         case (cur_phase)
            uted_pkg::PH_PRIMED: begin
               nxt_primed = primed_add;
               if (!sound) begin
                  flags.trim_preroll = 1'b1;
                  nxt_phase          = uted_pkg::PH_IDLE;
               end else if (reached(primed_add, cfg.burst_ms)) begin
                  nxt_phase             = uted_pkg::PH_SPEECH;
                  nxt_speech            = primed_add;
                  nxt_silence           = '0;
                  nxt_partial           = '0;
                  flags.utterance_start = 1'b1;
                  speech_length_ms      = primed_add;
               end
            end
            uted_pkg::PH_SPEECH: begin
               nxt_speech       = speech_add;
               nxt_silence      = silence_add;
               nxt_partial      = partial_add;
               speech_length_ms = speech_add;
               if (reached(partial_add, cfg.partial_period_ms)) begin
                  nxt_partial           = '0;
                  flags.partial_request = 1'b1;
               end
               if (reached(silence_add, cfg.silence_end_ms) ||
                   reached(speech_add, cfg.max_length_ms)) begin
                  nxt_phase = uted_pkg::PH_IDLE;
                  if (reached(speech_add, cfg.min_length_ms)) begin
                     flags.final_decode = 1'b1;
                  end else begin
                     flags.final_discard = 1'b1;
                  end
               end
            end
            default: begin
               // idle, and the unused code, behave as idle
               nxt_phase          = uted_pkg::PH_IDLE;
               flags.trim_preroll = 1'b1;
               if (sound) begin
                  nxt_phase  = uted_pkg::PH_PRIMED;
                  nxt_primed = '0;
               end
            end
         endcase
      end
   end

endmodule
